// ----- hdl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kinds and character codes for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Parameter defaults for the top level
    localparam int OFFSET_WIDTH_DEF    = 32;
    localparam int MAX_NAME_BYTES_DEF  = 8;
    localparam int TYPE_NAME_SLOTS_DEF = 4;

    // Fixed field widths
    localparam int POS_W      = 32;   // offset fields on the ports
    localparam int LC_W       = 16;   // line and column
    localparam int NAME_W     = 64;   // packed name / type name
    localparam int KIND_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;

    // Token queue between scanner and resolver
    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_PUSH    = 3;   // tokens one byte can produce
    localparam int PUSH_W      = 2;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
    localparam logic [KIND_W-1:0] KIND_TYPE   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INT    = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RETURN = 5'd3;
    localparam logic [KIND_W-1:0] KIND_IF     = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd8;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd10;
    localparam logic [KIND_W-1:0] KIND_ARROW  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_STAR   = 5'd12;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd14;
    localparam logic [KIND_W-1:0] KIND_EQEQ   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_AT     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd18;
    localparam logic [KIND_W-1:0] KIND_STRAY  = 5'd19;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;

    // Keywords, packed low byte first
    localparam logic [NAME_W-1:0] KW_RETURN = 64'h0000_6E72_7574_6572;
    localparam logic [NAME_W-1:0] KW_IF     = 64'h0000_0000_0000_6669;

    // One token record in the queue; names are resolved downstream
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_name;
        logic              name_long;
        logic [NAME_W-1:0] name;
        logic [POS_W-1:0]  start_off;
        logic [POS_W-1:0]  end_off;
        logic [LC_W-1:0]   line;
        logic [LC_W-1:0]   col;
        logic              last;
    } t_tok;

    // Queue status seen by the scanner and resolver
    typedef struct packed {
        logic empty;
        logic room;
    } t_q_stat;

endpackage

// ----- hdl/stt_scan.sv -----
// ----------------------------------------------------------------------------
// stt_scan
// Front end: accepts source bytes, tracks offset/line/column and the pending
// token, and writes up to three token records per byte into the queue.
// ----------------------------------------------------------------------------
module stt_scan #(
    parameter int OFFSET_WIDTH   = stt_pkg::OFFSET_WIDTH_DEF,
    parameter int MAX_NAME_BYTES = stt_pkg::MAX_NAME_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [7:0]                i_source_byte,
    input  logic                      i_end_of_text,
    input  stt_pkg::t_q_stat          i_q_stat,
    output logic [stt_pkg::PUSH_W-1:0] o_push_cnt,
    output stt_pkg::t_tok             o_push_tok [stt_pkg::MAX_PUSH]
);
    import stt_pkg::*;

    localparam int LEN_W = $clog2(MAX_NAME_BYTES + 2);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_NAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_LONG = LEN_W'(MAX_NAME_BYTES + 1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_NAME,
        M_DIGITS,
        M_MINUS,
        M_EQUALS
    } t_mode;

    t_mode                   r_mode, n_mode;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [NAME_W-1:0]       r_buf, n_buf;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [OFFSET_WIDTH-1:0] r_off, n_off;
    logic [LC_W-1:0]         r_line, n_line;
    logic [LC_W-1:0]         r_col, n_col;
    logic [LC_W-1:0]         r_pend_col, n_pend_col;

    logic                    accept;
    logic                    is_letter, is_digit, is_cont;
    logic                    used, newline;
    logic [OFFSET_WIDTH-1:0] off_next, off_after;
    logic [LC_W-1:0]         pos_line, pos_col;
    logic                    cand_v [MAX_PUSH];
    t_tok                    cand   [MAX_PUSH];
    logic [PUSH_W-1:0]       cnt;

    // Low 32 bits of an offset, zero-extended when the offset is narrower
    function automatic logic [POS_W-1:0] to_pos(input logic [OFFSET_WIDTH-1:0] v);
        logic [OFFSET_WIDTH+POS_W-1:0] w;
        w = {{POS_W{1'b0}}, v};
        return w[POS_W-1:0];
    endfunction

    // Record for a pending token that is closed
    function automatic t_tok pend_tok(
        input t_mode                   m,
        input logic [NAME_W-1:0]       nm,
        input logic [LEN_W-1:0]        len,
        input logic [OFFSET_WIDTH-1:0] s,
        input logic [OFFSET_WIDTH-1:0] e,
        input logic [LC_W-1:0]         ln,
        input logic [LC_W-1:0]         cl
    );
        t_tok t;
        t           = '0;
        t.name      = nm;
        t.name_long = (len > LEN_MAX);
        t.start_off = to_pos(s);
        t.end_off   = to_pos(e);
        t.line      = ln;
        t.col       = cl;
        unique case (m)
            M_NAME: begin
                t.kind    = KIND_IDENT;
                t.is_name = 1'b1;
            end
            M_DIGITS: t.kind = KIND_INT;
            M_MINUS:  t.kind = KIND_MINUS;
            M_EQUALS: t.kind = KIND_ASSIGN;
            default:  t.kind = KIND_STRAY;
        endcase
        return t;
    endfunction

    // Plain token record
    function automatic t_tok plain_tok(
        input logic [KIND_W-1:0]       k,
        input logic [OFFSET_WIDTH-1:0] s,
        input logic [OFFSET_WIDTH-1:0] e,
        input logic [LC_W-1:0]         ln,
        input logic [LC_W-1:0]         cl,
        input logic                    lst
    );
        t_tok t;
        t           = '0;
        t.kind      = k;
        t.start_off = to_pos(s);
        t.end_off   = to_pos(e);
        t.line      = ln;
        t.col       = cl;
        t.last      = lst;
        return t;
    endfunction

    assign accept = i_in_valid && i_q_stat.room;

    // Byte classes
    assign is_letter = ((i_source_byte >= 8'h61) && (i_source_byte <= 8'h7A)) ||
                       ((i_source_byte >= 8'h41) && (i_source_byte <= 8'h5A));
    assign is_digit  = (i_source_byte >= 8'h30) && (i_source_byte <= 8'h39);
    assign is_cont   = is_letter || is_digit || (i_source_byte == CH_UNDER);

    assign off_next  = r_off + 1'b1;
    assign off_after = off_next + 1'b1;

    // Scan step: close / own token / end-of-text flush / eof
    always_comb begin
        n_mode     = r_mode;
        n_start    = r_start;
        n_buf      = r_buf;
        n_len      = r_len;
        n_pend_col = r_pend_col;
        used       = 1'b0;
        newline    = 1'b0;
        for (int i = 0; i < MAX_PUSH; i++) begin
            cand_v[i] = 1'b0;
            cand[i]   = '0;
        end

        // Extend or close the pending token
        unique case (r_mode)
            M_NAME: begin
                if (is_cont) begin
                    used       = 1'b1;
                    n_pend_col = r_col;
                    if (r_len < LEN_MAX) begin
                        n_buf[8*r_len[2:0] +: 8] = i_source_byte;
                        n_len                    = r_len + 1'b1;
                    end else begin
                        n_len = LEN_LONG;
                    end
                end
            end
            M_DIGITS: begin
                if (is_digit) begin
                    used       = 1'b1;
                    n_pend_col = r_col;
                end
            end
            M_MINUS: begin
                if (i_source_byte == CH_GT) begin
                    used      = 1'b1;
                    n_mode    = M_IDLE;
                    cand_v[0] = 1'b1;
                    cand[0]   = plain_tok(KIND_ARROW, r_start, off_next, r_line, r_col,
                                          1'b0);
                end
            end
            M_EQUALS: begin
                if (i_source_byte == CH_EQUALS) begin
                    used      = 1'b1;
                    n_mode    = M_IDLE;
                    cand_v[0] = 1'b1;
                    cand[0]   = plain_tok(KIND_EQEQ, r_start, off_next, r_line, r_col,
                                          1'b0);
                end
            end
            default: ;
        endcase

        if (!used) begin
            if (r_mode != M_IDLE) begin
                cand_v[0] = 1'b1;
                cand[0]   = pend_tok(r_mode, r_buf, r_len, r_start, r_off, r_line,
                                     r_pend_col);
                n_mode    = M_IDLE;
            end
            if (is_letter || is_digit || (i_source_byte == CH_MINUS) ||
                (i_source_byte == CH_EQUALS)) begin
                // Start a new pending token
                priority if (is_letter)                n_mode = M_NAME;
                else if (is_digit)                     n_mode = M_DIGITS;
                else if (i_source_byte == CH_MINUS)    n_mode = M_MINUS;
                else                                   n_mode = M_EQUALS;
                n_start    = r_off;
                n_pend_col = r_col;
                n_buf      = is_letter ? {{(NAME_W-BYTE_W){1'b0}}, i_source_byte} : '0;
                n_len      = is_letter ? LEN_W'(1) : '0;
            end else begin
                // Single byte tokens
                cand_v[1] = 1'b1;
                unique case (i_source_byte)
                    CH_LPAREN:  cand[1].kind = KIND_LPAREN;
                    CH_RPAREN:  cand[1].kind = KIND_RPAREN;
                    CH_LBRACE:  cand[1].kind = KIND_LBRACE;
                    CH_RBRACE:  cand[1].kind = KIND_RBRACE;
                    CH_PLUS:    cand[1].kind = KIND_PLUS;
                    CH_STAR:    cand[1].kind = KIND_STAR;
                    CH_SLASH:   cand[1].kind = KIND_SLASH;
                    CH_AT:      cand[1].kind = KIND_AT;
                    CH_SEMI:    cand[1].kind = KIND_SEMI;
                    CH_NEWLINE: begin
                        cand_v[1] = 1'b0;
                        newline   = 1'b1;
                    end
                    CH_SPACE:   cand_v[1] = 1'b0;
                    default:    cand[1].kind = KIND_STRAY;
                endcase
                cand[1] = plain_tok(cand[1].kind, r_off, off_next, r_line, r_col, 1'b0);
            end
        end

        // Position after this byte, saturating
        if (newline) begin
            pos_line = (r_line != '1) ? r_line + 1'b1 : r_line;
            pos_col  = LC_W'(1);
        end else begin
            pos_line = r_line;
            pos_col  = (r_col != '1) ? r_col + 1'b1 : r_col;
        end
        n_off  = off_next;
        n_line = pos_line;
        n_col  = pos_col;

        // End of text: flush, eof, start afresh
        if (i_end_of_text) begin
            if (n_mode != M_IDLE) begin
                cand_v[1] = 1'b1;
                cand[1]   = pend_tok(n_mode, n_buf, n_len, n_start, off_next, pos_line,
                                     n_pend_col);
            end
            cand_v[2]  = 1'b1;
            cand[2]    = plain_tok(KIND_EOF, off_next, off_after, pos_line, pos_col, 1'b1);
            n_mode     = M_IDLE;
            n_start    = '0;
            n_buf      = '0;
            n_len      = '0;
            n_off      = '0;
            n_line     = LC_W'(1);
            n_col      = LC_W'(1);
            n_pend_col = '0;
        end
    end

    // Pack the candidate tokens in order
    always_comb begin
        cnt = '0;
        for (int i = 0; i < MAX_PUSH; i++) begin
            o_push_tok[i] = cand[i];
        end
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (cand_v[i]) begin
                o_push_tok[cnt] = cand[i];
                cnt             = cnt + 1'b1;
            end
        end
        o_push_cnt = accept ? cnt : '0;
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_off  <= '0;
            r_line <= LC_W'(1);
            r_col  <= LC_W'(1);
        end else if (accept) begin
            r_mode <= n_mode;
            r_off  <= n_off;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start    <= n_start;
            r_buf      <= n_buf;
            r_len      <= n_len;
            r_pend_col <= n_pend_col;
        end
    end

    // End of text leaves the scanner at the start of a fresh text
    a_eot_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_text) |=>
            (r_mode == M_IDLE) && (r_off == '0) && (r_line == LC_W'(1)) &&
            (r_col == LC_W'(1)))
        else $error("scanner not cleared after end of text");

    // Each other byte moves the offset by one
    a_off_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_end_of_text) |=> (r_off == $past(r_off) + 1'b1))
        else $error("byte offset did not advance by one");

endmodule

// ----- hdl/stt_tok_fifo.sv -----
// ----------------------------------------------------------------------------
// stt_tok_fifo
// Token queue: takes up to three records per cycle from the scanner, hands
// one record per cycle to the resolver whenever the resolver pops.
// ----------------------------------------------------------------------------
module stt_tok_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [stt_pkg::PUSH_W-1:0] i_push_cnt,
    input  stt_pkg::t_tok              i_push_tok [stt_pkg::MAX_PUSH],
    input  logic                       i_pop,
    output stt_pkg::t_tok              o_head,
    output stt_pkg::t_q_stat           o_stat
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_tok             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.room  = (r_count <= CNT_W'(QUEUE_DEPTH - MAX_PUSH));

    // Storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (PUSH_W'(k) < i_push_cnt) begin
                r_mem[r_wr + PTR_W'(k)] <= i_push_tok[k];
            end
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push_cnt);
            r_rd    <= r_rd + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
        end
    end

    // Writes only land where there was room for a full burst
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != '0) |-> o_stat.room)
        else $error("token queue written without room");

    // Pointer distance matches the fill level
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wr - r_rd) == r_count[PTR_W-1:0]) && (r_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("token queue pointers disagree with count");

endmodule

// ----- hdl/stt_resolve.sv -----
// ----------------------------------------------------------------------------
// stt_resolve
// Back end: holds the type name registers, resolves names into identifier,
// keyword or type tokens and drives the output register.
// ----------------------------------------------------------------------------
module stt_resolve #(
    parameter int TYPE_NAME_SLOTS = stt_pkg::TYPE_NAME_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [stt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stt_pkg::NAME_W-1:0]    i_cfg_data,
    output logic                          o_cfg_ready,
    input  stt_pkg::t_tok                 i_head,
    input  stt_pkg::t_q_stat              i_q_stat,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [stt_pkg::KIND_W-1:0]    o_token_kind,
    output logic [stt_pkg::POS_W-1:0]     o_start_offset,
    output logic [stt_pkg::POS_W-1:0]     o_end_offset,
    output logic [stt_pkg::LC_W-1:0]      o_line_number,
    output logic [stt_pkg::LC_W-1:0]      o_column_number,
    output logic                          o_last_token
);
    import stt_pkg::*;

    logic [NAME_W-1:0] r_type_name [TYPE_NAME_SLOTS];
    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_start, r_end;
    logic [LC_W-1:0]   r_line, r_col;
    logic              r_last;
    logic              type_hit;
    logic [KIND_W-1:0] n_kind;

    assign o_cfg_ready = 1'b1;

    // Type name registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TYPE_NAME_SLOTS; i++) begin
                r_type_name[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < TYPE_NAME_SLOTS; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_type_name[i] <= i_cfg_data;
                end
            end
        end
    end

    // Keyword and type name match on the queue head
    always_comb begin
        type_hit = 1'b0;
        for (int i = 0; i < TYPE_NAME_SLOTS; i++) begin
            if ((r_type_name[i] != '0) && (r_type_name[i] == i_head.name)) begin
                type_hit = 1'b1;
            end
        end
        n_kind = i_head.kind;
        if (i_head.is_name && !i_head.name_long) begin
            priority if (i_head.name == KW_RETURN) n_kind = KIND_RETURN;
            else if (i_head.name == KW_IF)         n_kind = KIND_IF;
            else if (type_hit)                     n_kind = KIND_TYPE;
            else                                   n_kind = KIND_IDENT;
        end
    end

    // Output register refills whenever it is empty or being taken
    assign o_pop = !i_q_stat.empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= n_kind;
            r_start <= i_head.start_off;
            r_end   <= i_head.end_off;
            r_line  <= i_head.line;
            r_col   <= i_head.col;
            r_last  <= i_head.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_token_kind    = r_kind;
    assign o_start_offset  = r_start;
    assign o_end_offset    = r_end;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;
    assign o_last_token    = r_last;

    // The last flag marks exactly the eof token
    a_last_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_last == (r_kind == KIND_EOF)))
        else $error("last flag and eof kind disagree");

    // Lines count from one
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_line != '0))
        else $error("token carries line zero");

endmodule

// ----- hdl/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one source byte in, identifier/keyword/type/integer/
// punctuation/eof tokens out with offsets, line and column.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle as long as its eight-entry token
// queue has room for three more tokens; o_in_stall rises only when fewer than
// three entries are free. Tokens leave one per cycle while the output is not
// stalled, so a byte stream that yields more than one token per byte (a closed
// token followed by punctuation, or the flush and eof tokens on the final byte)
// fills the queue and briefly stalls the input until the output drains it. A
// token that a byte completes is written into the queue by the scanner at the
// accepting edge; the resolver, which matches names against "return", "if" and
// the type name registers, loads it into the output register when it pops it
// from the head of the queue. Type name registers are written through the config
// channel, which is always ready; write them only while no text is in flight.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int OFFSET_WIDTH    = stt_pkg::OFFSET_WIDTH_DEF,
    parameter int MAX_NAME_BYTES  = stt_pkg::MAX_NAME_BYTES_DEF,
    parameter int TYPE_NAME_SLOTS = stt_pkg::TYPE_NAME_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // source byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_source_byte,
    input  logic                          i_end_of_text,
    // token channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [stt_pkg::KIND_W-1:0]    o_token_kind,
    output logic [stt_pkg::POS_W-1:0]     o_start_offset,
    output logic [stt_pkg::POS_W-1:0]     o_end_offset,
    output logic [stt_pkg::LC_W-1:0]      o_line_number,
    output logic [stt_pkg::LC_W-1:0]      o_column_number,
    output logic                          o_last_token,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stt_pkg::NAME_W-1:0]    i_cfg_data
);
    import stt_pkg::*;

    logic [PUSH_W-1:0] push_cnt;
    t_tok              push_tok [MAX_PUSH];
    t_tok              head;
    t_q_stat           q_stat;
    logic              pop;

    assign o_in_stall = !q_stat.room;

    // Front: scanner
    stt_scan #(
        .OFFSET_WIDTH   (OFFSET_WIDTH),
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_source_byte (i_source_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_stat      (q_stat),
        .o_push_cnt    (push_cnt),
        .o_push_tok    (push_tok)
    );

    // Token queue
    stt_tok_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push_tok (push_tok),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    // Back: name resolution and output register
    stt_resolve #(
        .TYPE_NAME_SLOTS (TYPE_NAME_SLOTS)
    ) u_resolve (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cfg_ready     (o_cfg_ready),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_kind    (o_token_kind),
        .o_start_offset  (o_start_offset),
        .o_end_offset    (o_end_offset),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_token    (o_last_token)
    );

endmodule

// ----- test/tb_source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Self-checking testbench for the streaming source text tokenizer.
// ----------------------------------------------------------------------------
// Source texts are fed one byte per transfer, and the final byte of each text
// is flagged. A scoreboard model inside the bench tracks offset, line, column
// and the pending token. From every accepted byte it predicts the tokens that
// the byte completes. Each token transfer on the output is checked field by
// field against the oldest prediction.
// Coverage comes from:
//   - a short directed text that holds every punctuation kind and stray bytes,
//   - several type name register settings, their extremes among them,
//   - runs of blank lines and spaces that move line and column along,
//   - random texts built from keywords, names, numbers and noise bytes.
// Both channels idle in random bursts, save in the blank runs and final phase.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int NAME_MAX      = MAX_NAME_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8;      // pipeline depth plus margin
    localparam int STALL_LIMIT   = 2000;   // cycles with no transfer at all
    localparam int BLANK_RUN     = 10;     // newlines, then spaces, in one text

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_D = 2'd3;

    // "ab", zero, "cd": a slot that no scanned name can equal
    localparam logic [NAME_W-1:0] INNER_ZERO_NAME = 64'h0000_0064_6300_6261;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NAME,
        SCAN_DIGITS,
        SCAN_MINUS,
        SCAN_EQUALS
    } t_scan_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start_off;
        logic [POS_W-1:0]  end_off;
        logic [LC_W-1:0]   line;
        logic [LC_W-1:0]   col;
        logic              last;
    } t_token;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_source_byte = '0;
    logic                 i_end_of_text = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [KIND_W-1:0]    o_token_kind;
    logic [POS_W-1:0]     o_start_offset;
    logic [POS_W-1:0]     o_end_offset;
    logic [LC_W-1:0]      o_line_number;
    logic [LC_W-1:0]      o_column_number;
    logic                 o_last_token;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [NAME_W-1:0]    i_cfg_data = '0;

    // Scanner model state
    t_scan_mode        scan_mode;
    logic [POS_W-1:0]  tok_start;
    logic [NAME_W-1:0] name_buf;
    int                name_len;
    logic [POS_W-1:0]  byte_off;
    logic [LC_W-1:0]   line_cnt;
    logic [LC_W-1:0]   col_cnt;
    logic [LC_W-1:0]   pend_col;
    logic [NAME_W-1:0] type_slot [4];

    t_token            tokens_due [$];

    // Stimulus bookkeeping
    logic [BYTE_W-1:0] text_bytes [$];
    logic [NAME_W-1:0] name_setting [4];
    bit                idle_on = 1'b1;
    int                idle_odds = 4;
    int                stall_left = 0;
    int                quiet_cycles = 0;
    int                fail_count = 0;
    int                bytes_sent = 0;
    int                texts_sent = 0;
    int                tokens_checked = 0;
    int                cfg_writes = 0;

    source_text_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_source_byte   (i_source_byte),
        .i_end_of_text   (i_end_of_text),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_kind    (o_token_kind),
        .o_start_offset  (o_start_offset),
        .o_end_offset    (o_end_offset),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_token    (o_last_token),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic clear_text();
        scan_mode = SCAN_IDLE;
        tok_start = '0;
        name_buf  = '0;
        name_len  = 0;
        byte_off  = '0;
        line_cnt  = 16'd1;
        col_cnt   = 16'd1;
        pend_col  = '0;
    endtask

    task automatic push_token(logic [KIND_W-1:0] kind, logic [POS_W-1:0] s,
                              logic [POS_W-1:0] e, logic [LC_W-1:0] col,
                              logic last);
        t_token t;
        t.kind      = kind;
        t.start_off = s;
        t.end_off   = e;
        t.line      = line_cnt;
        t.col       = col;
        t.last      = last;
        tokens_due.insert(tokens_due.size(), t);
    endtask

    // Keywords win over type names; overlong names are plain identifiers
    function automatic logic [KIND_W-1:0] name_kind();
        if (name_len > NAME_MAX) return KIND_IDENT;
        if (name_buf == KW_RETURN) return KIND_RETURN;
        if (name_buf == KW_IF) return KIND_IF;
        for (int i = 0; i < 4; i++)
            if (type_slot[i] != '0 && type_slot[i] == name_buf) return KIND_TYPE;
        return KIND_IDENT;
    endfunction

    task automatic close_pending(logic [POS_W-1:0] e);
        logic [KIND_W-1:0] kind;
        case (scan_mode)
            SCAN_NAME:   kind = name_kind();
            SCAN_DIGITS: kind = KIND_INT;
            SCAN_MINUS:  kind = KIND_MINUS;
            default:     kind = KIND_ASSIGN;
        endcase
        push_token(kind, tok_start, e, pend_col, 1'b0);
        scan_mode = SCAN_IDLE;
    endtask

    // Predict the tokens one accepted source byte produces
    task automatic scan_source_byte(logic [7:0] b, logic eot);
        logic [POS_W-1:0]  off;
        logic [POS_W-1:0]  nxt;
        logic [LC_W-1:0]   col;
        logic [KIND_W-1:0] kind;
        bit                used;
        bit                newline;
        bit                emit;
        bit                let_b;
        bit                dig_b;
        off     = byte_off;
        nxt     = off + 1'b1;
        col     = col_cnt;
        used    = 1'b0;
        newline = 1'b0;
        let_b   = is_letter(b);
        dig_b   = is_digit(b);

        // extend or close the pending token
        case (scan_mode)
            SCAN_NAME: begin
                if (let_b || dig_b || b == CH_UNDER) begin
                    if (name_len < NAME_MAX) begin
                        name_buf[8*name_len +: 8] = b;
                        name_len++;
                    end else begin
                        name_len = NAME_MAX + 1;
                    end
                    pend_col = col;
                    used = 1'b1;
                end
            end
            SCAN_DIGITS: begin
                if (dig_b) begin
                    pend_col = col;
                    used = 1'b1;
                end
            end
            SCAN_MINUS: begin
                if (b == CH_GT) begin
                    push_token(KIND_ARROW, tok_start, nxt, col, 1'b0);
                    scan_mode = SCAN_IDLE;
                    used = 1'b1;
                end
            end
            SCAN_EQUALS: begin
                if (b == CH_EQUALS) begin
                    push_token(KIND_EQEQ, tok_start, nxt, col, 1'b0);
                    scan_mode = SCAN_IDLE;
                    used = 1'b1;
                end
            end
            default: ;
        endcase

        // the byte starts something of its own
        if (!used) begin
            if (scan_mode != SCAN_IDLE) close_pending(off);
            if (let_b || dig_b || b == CH_MINUS || b == CH_EQUALS) begin
                scan_mode = let_b ? SCAN_NAME : dig_b ? SCAN_DIGITS :
                            (b == CH_MINUS) ? SCAN_MINUS : SCAN_EQUALS;
                tok_start = off;
                pend_col  = col;
                name_buf  = let_b ? {56'd0, b} : '0;
                name_len  = let_b ? 1 : 0;
            end else begin
                emit = 1'b1;
                kind = KIND_STRAY;
                case (b)
                    CH_LPAREN:  kind = KIND_LPAREN;
                    CH_RPAREN:  kind = KIND_RPAREN;
                    CH_LBRACE:  kind = KIND_LBRACE;
                    CH_RBRACE:  kind = KIND_RBRACE;
                    CH_PLUS:    kind = KIND_PLUS;
                    CH_STAR:    kind = KIND_STAR;
                    CH_SLASH:   kind = KIND_SLASH;
                    CH_AT:      kind = KIND_AT;
                    CH_SEMI:    kind = KIND_SEMI;
                    CH_NEWLINE: begin
                        emit = 1'b0;
                        newline = 1'b1;
                    end
                    CH_SPACE:   emit = 1'b0;
                    default: ;
                endcase
                if (emit) push_token(kind, off, nxt, col, 1'b0);
            end
        end

        // position update, saturating line and column
        byte_off = nxt;
        if (newline) begin
            if (line_cnt != 16'hFFFF) line_cnt++;
            col_cnt = 16'd1;
        end else if (col_cnt != 16'hFFFF) begin
            col_cnt++;
        end

        if (eot) begin
            if (scan_mode != SCAN_IDLE) close_pending(nxt);
            push_token(KIND_EOF, nxt, nxt + 1'b1, col_cnt, 1'b1);
            clear_text();
        end
    endtask

    task automatic check_token();
        t_token want;
        if (tokens_due.size() == 0) begin
            $error("token with none expected: kind %0d start %0d",
                   o_token_kind, o_start_offset);
            fail_count++;
        end else begin
            want = tokens_due.pop_front();
            tokens_checked++;
            if (o_token_kind !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                fail_count++;
            end
            if (o_start_offset !== want.start_off) begin
                $error("start_offset: expected %0d, got %0d",
                       want.start_off, o_start_offset);
                fail_count++;
            end
            if (o_end_offset !== want.end_off) begin
                $error("end_offset: expected %0d, got %0d", want.end_off, o_end_offset);
                fail_count++;
            end
            if (o_line_number !== want.line) begin
                $error("line_number: expected %0d, got %0d", want.line, o_line_number);
                fail_count++;
            end
            if (o_column_number !== want.col) begin
                $error("column_number: expected %0d, got %0d", want.col, o_column_number);
                fail_count++;
            end
            if (o_last_token !== want.last) begin
                $error("last_token: expected %0d, got %0d", want.last, o_last_token);
                fail_count++;
            end
        end
    endtask

    // Monitor: config writes and source bytes feed the model, tokens are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) type_slot[i] = '0;
            clear_text();
            tokens_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) type_slot[i_cfg_index] = i_cfg_data;
            if (i_in_valid && !o_in_stall) scan_source_byte(i_source_byte, i_end_of_text);
            if (o_out_valid && !i_out_stall) check_token();
        end
    end

    // Token receiver: stalls the output in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, idle_odds) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(logic [7:0] b, logic eot);
        if (idle_on && $urandom_range(0, idle_odds) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_source_byte <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_for_tokens();
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    // Stop sending and let the pipeline empty out
    task automatic settle();
        i_in_valid <= 1'b0;
        wait_for_tokens();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high so back-to-back writes need one assignment per step
    task automatic write_type_name(logic [CFG_IDX_W-1:0] idx, logic [NAME_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        name_setting[idx] = value;
        cfg_writes++;
    endtask

    task automatic load_type_names(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b,
                                   logic [NAME_W-1:0] c, logic [NAME_W-1:0] d);
        write_type_name(REG_TYPE_A, a);
        write_type_name(REG_TYPE_B, b);
        write_type_name(REG_TYPE_C, c);
        write_type_name(REG_TYPE_D, d);
        i_cfg_valid <= 1'b0;
    endtask

    // Send the built text, flag its last byte; optionally drain midway
    task automatic send_text(int pause_at);
        int count;
        count = text_bytes.size();
        for (int i = 0; i < count; i++) begin
            if (i == pause_at && i > 0) begin
                i_in_valid <= 1'b0;
                wait_for_tokens();
            end
            send_item(text_bytes[i], i == count - 1);
        end
        texts_sent++;
        text_bytes.delete();
    endtask

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------
    function automatic logic [NAME_W-1:0] pack_name(string s);
        logic [NAME_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    // Append one byte to the text under construction
    task automatic add_byte(logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                    : 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_name_char();
        case ($urandom_range(0, 3))
            0, 1:    return rand_letter();
            2:       return 8'("0" + $urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    // Append one lexical piece plus an optional separator
    task automatic add_fragment();
        logic [NAME_W-1:0] slot;
        int                len;
        case ($urandom_range(0, 15))
            0: add_str("return");
            1: add_str("if");
            2, 3: begin
                // configured type name, sometimes stretched past it
                slot = name_setting[$urandom_range(0, 3)];
                for (int i = 0; i < 8; i++) begin
                    if (slot[8*i +: 8] == 8'h00) break;
                    add_byte(slot[8*i +: 8]);
                end
                if ($urandom_range(0, 2) == 0) add_byte(rand_name_char());
            end
            4, 5: begin
                len = $urandom_range(1, 12);
                add_byte(rand_letter());
                for (int i = 1; i < len; i++) add_byte(rand_name_char());
            end
            6: begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) add_byte(8'("0" + $urandom_range(0, 9)));
            end
            7: begin
                case ($urandom_range(0, 8))
                    0: add_byte(CH_LPAREN);
                    1: add_byte(CH_RPAREN);
                    2: add_byte(CH_LBRACE);
                    3: add_byte(CH_RBRACE);
                    4: add_byte(CH_PLUS);
                    5: add_byte(CH_STAR);
                    6: add_byte(CH_SLASH);
                    7: add_byte(CH_AT);
                    default: add_byte(CH_SEMI);
                endcase
            end
            8:  add_str("->");
            9:  add_str("==");
            10: add_byte($urandom_range(0, 1) ? CH_MINUS : CH_EQUALS);
            11: add_byte(CH_NEWLINE);
            12: add_byte(8'($urandom_range(0, 255)));
            13: add_byte(CH_GT);
            default: begin
                // near misses of the keywords
                case ($urandom_range(0, 5))
                    0: add_str("ret");
                    1: add_str("iff");
                    2: add_str("returns");
                    3: add_str("If");
                    4: add_str("RETURN");
                    default: add_str("return_");
                endcase
            end
        endcase
        case ($urandom_range(0, 3))
            1, 2: add_byte(CH_SPACE);
            default: ;
        endcase
    endtask

    // Random texts until about n_bytes have been sent
    task automatic run_random_texts(int n_bytes, bit with_pause);
        int target;
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            target = $urandom_range(1, 24);
            while (text_bytes.size() < target) add_fragment();
            send_text(with_pause ? text_bytes.size() / 2 : -1);
            with_pause = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Every punctuation kind, the two pairs, strays and flushes at end of text
    task automatic test_directed_punctuation();
        add_str("(){}+*/@;->==-= _\tA9z_0");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_NEWLINE);
        add_byte(CH_MINUS);
        send_text(-1);
        add_str("7");
        send_text(-1);
        settle();
    endtask

    // Several register settings; keyword names in slots, all ones, full width
    task automatic test_type_name_sets();
        idle_odds = 4;
        load_type_names(pack_name("int"), pack_name("char"), pack_name("u8"),
                        pack_name("Float"));
        run_random_texts(55, 1'b0);
        settle();
        idle_odds = 9;
        load_type_names({NAME_W{1'b1}}, pack_name("return"), pack_name("if"), '0);
        run_random_texts(55, 1'b1);
        settle();
        idle_odds = 3;
        load_type_names(pack_name("abcdefgh"), pack_name("Type_123"), INNER_ZERO_NAME,
                        pack_name("x"));
        run_random_texts(55, 1'b0);
        settle();
    endtask

    // Runs of newlines then spaces move line and column well past their start
    task automatic test_blank_runs();
        idle_on = 1'b0;
        for (int i = 0; i < BLANK_RUN; i++) add_byte(CH_NEWLINE);
        add_str("x ");
        for (int i = 0; i < BLANK_RUN; i++) add_byte(CH_SPACE);
        add_str("ab1 ==");
        send_text(-1);
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_cleared_type_names();
        idle_odds = 5;
        load_type_names('0, '0, '0, '0);
        run_random_texts(55, 1'b0);
        settle();
    endtask

    // Closing phase at full rate on both channels
    task automatic test_full_rate();
        idle_on = 1'b0;
        load_type_names(pack_name("int"), pack_name("i"), pack_name("Tname_9Z"),
                        pack_name("void"));
        run_random_texts(55, 1'b0);
        settle();
    endtask

    initial begin
        for (int i = 0; i < 4; i++) name_setting[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_punctuation();
        test_type_name_sets();
        test_blank_runs();
        test_cleared_type_names();
        test_full_rate();

        if (tokens_due.size() != 0) begin
            $error("%0d tokens never arrived", tokens_due.size());
            fail_count++;
        end
        $display("Covered %0d texts, %0d source bytes and %0d checked tokens,",
                 texts_sent, bytes_sent, tokens_checked);
        $display("with %0d type name writes over five settings and runs of blank lines.",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
